// File: src/sem_pkg.sv
`default_nettype none
package sem_pkg;

   localparam int MaxWidthDefault = 1024;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_SQRT,
      ST_OUT
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic start;     // latch accepted transaction, launch line store read
      logic step;      // perform one advance pass
      logic sqrt_go;   // set on a result pass; the datapath starts the square root itself
      logic send;      // load output register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic act_ok;    // transaction does something
      logic again;     // flush needs second pass
      logic emitted;   // a result was computed
      logic sqrt_done;
   } sts_type;

   localparam int unsigned CfgWidthIdx  = 0;
   localparam int unsigned CfgHeightIdx = 1;

endpackage
`default_nettype wire

// File: src/sem_sqrt.sv
`default_nettype none
module sem_sqrt
   import sem_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [17:0] sum_in,
   output logic             done,
   output logic [7:0]       root
);
   // one result bit per cycle, MSB first, then a round step
   logic [17:0] s_ff, s_in;
   logic [8:0]  q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;
   logic [17:0] sq;

   always_comb begin
      trial = q_ff | (9'd1 << cnt_ff);
      sq = 18'(trial) * 18'(trial);
   end

   always_comb begin
      s_in = s_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         s_in = sum_in;
         q_in = '0;
         cnt_in = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff <= 4'd8) begin
            if (sq <= s_ff) q_in = trial;
            if (cnt_ff == 4'd0) cnt_in = 4'd15;
            else cnt_in = cnt_ff - 4'd1;
         end else begin
            // round half up: s > q*q + q
            if (s_ff > 18'(q_ff) * 18'(q_ff) + 18'(q_ff)) q_in = q_ff + 9'd1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      s_ff <= s_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign root = (q_ff > 9'd255) ? 8'd255 : q_ff[7:0];

   a_start_not_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("sqrt restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
endmodule
`default_nettype wire

// File: src/sem_ctrl.sv
`default_nettype none
module sem_ctrl
   import sem_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_fire,
   input  wire logic out_busy,
   input  sts_type   sts,
   output cmd_type   cmd,
   output logic      req_ready
);
   state_type st_ff, st_in;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (in_fire) st_in = ST_READ;
         ST_READ: st_in = sts.act_ok ? ST_STEP : ST_IDLE;
         ST_STEP: begin
            if (sts.emitted) st_in = ST_SQRT;
            else if (sts.again) st_in = ST_READ;
            else st_in = ST_IDLE;
         end
         ST_SQRT: if (sts.sqrt_done) st_in = ST_OUT;
         ST_OUT:  if (!out_busy) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = in_fire;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            cmd.sqrt_go = sts.emitted;
         end
         ST_OUT:  cmd.send = !out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_send_once: assert property (@(posedge clock) disable iff (reset)
      cmd.send |=> st_ff == ST_IDLE) else $error("send not closing");
   a_sqrt_after_step: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_SQRT |-> $past(st_ff) == ST_STEP || $past(st_ff) == ST_SQRT)
      else $error("bad sqrt entry");
endmodule
`default_nettype wire

// File: src/sem_dp.sv
`default_nettype none
module sem_dp
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MaxWidthDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  wire logic        in_action,
   input  wire logic [23:0] in_pix,
   input  wire logic [10:0] image_width,
   input  wire logic [15:0] image_height,
   output logic [23:0]      res_edge,
   output logic             res_last
);
   localparam int AW = $clog2(MAX_WIDTH);

   // line stores, one read per pass
   logic [23:0] upper_mem [MAX_WIDTH];
   logic [23:0] lower_mem [MAX_WIDTH];
   logic [23:0] up_rd_ff, lo_rd_ff;

   logic [23:0] win_ff [9];
   logic [23:0] win_in [9];
   logic [15:0] in_col_ff, out_col_ff, out_row_ff;
   logic [15:0] in_col_in, out_col_in, out_row_in;
   logic [16:0] in_row_ff, in_row_in;   // reaches height + 1 while draining
   logic        real_ff;
   logic [23:0] pix_ff;
   logic        pass2_ff, pass2_in;
   logic        emit_ff, final_ff;
   logic [1:0]  ch_ff;
   logic [23:0] res_ff;

   // effective sizes
   logic [15:0] w_eff, h_eff;
   logic [AW-1:0] ci;
   always_comb begin
      if (image_width == 11'd0) w_eff = 16'd1;
      else if (32'(image_width) > MAX_WIDTH) w_eff = 16'(MAX_WIDTH);
      else w_eff = 16'(image_width);
      h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
      ci = in_col_ff[AW-1:0];
   end

   logic draining;
   assign draining = in_row_ff >= 17'(h_eff);

   // line store read and write
   always_ff @(posedge clock) begin
      up_rd_ff <= upper_mem[ci];
      lo_rd_ff <= lower_mem[ci];
      if (cmd.step && real_ff) begin
         upper_mem[ci] <= lo_rd_ff;
         lower_mem[ci] <= pix_ff;
      end
   end

   // one advance pass
   logic        may_emit, fin, emit_now;
   logic [23:0] w0 [9];
   logic [23:0] comp_win [9];
   always_comb begin
      may_emit = (in_row_ff >= 17'd2) || (in_row_ff == 17'd1 && in_col_ff != 16'd0);
      fin = 1'b0;
      emit_now = 1'b0;
      for (int i = 0; i < 9; i++) w0[i] = win_ff[i];
      if (in_col_ff == 16'd0) begin
         for (int i = 0; i < 3; i++) begin
            w0[i*3] = win_ff[i*3+1];
            w0[i*3+1] = win_ff[i*3+2];
            w0[i*3+2] = '0;
         end
         if (!real_ff && in_row_ff >= 17'(h_eff) + 17'd1) fin = 1'b1;
      end
      for (int i = 0; i < 9; i++) win_in[i] = w0[i];
      for (int i = 0; i < 9; i++) comp_win[i] = w0[i];
      if (!fin) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i*3] = w0[i*3+1];
            win_in[i*3+1] = w0[i*3+2];
         end
         win_in[2] = up_rd_ff;
         win_in[5] = lo_rd_ff;
         win_in[8] = real_ff ? pix_ff : 24'd0;
      end
      if (in_col_ff == 16'd0) emit_now = may_emit;
      else begin
         emit_now = may_emit;
         for (int i = 0; i < 9; i++) comp_win[i] = win_in[i];
      end
   end

   // counter update
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pass2_in = 1'b0;
      if (fin) begin
         in_col_in = '0; in_row_in = '0; out_col_in = '0; out_row_in = '0;
      end else begin
         if (17'(in_col_ff) + 17'd1 >= 17'(w_eff)) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 17'd1;
         end else in_col_in = in_col_ff + 16'd1;
         if (emit_now) begin
            if (17'(out_col_ff) + 17'd1 >= 17'(w_eff)) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 16'd1;
            end else out_col_in = out_col_ff + 16'd1;
         end
         pass2_in = !real_ff && !emit_now && !pass2_ff;
      end
   end

   // masked window kept for the channel pass
   logic [23:0] cw_ff [9];
   logic [8:0]  mask_ff;
   logic [8:0]  mask;
   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            mask[i*3+j] = !((i == 0 && out_row_ff == 16'd0) ||
                            (i == 2 && 17'(out_row_ff) + 17'd1 >= 17'(h_eff)) ||
                            (j == 0 && out_col_ff == 16'd0) ||
                            (j == 2 && 17'(out_col_ff) + 17'd1 >= 17'(w_eff)));
   end

   logic        sq_start, sq_done;
   logic [7:0]  sq_root;
   logic        chan_busy_ff;
   logic [1:0]  ch_sel;

   // channel fed to the root unit: the next one on the cycle a root completes
   assign ch_sel = (sq_done && ch_ff != 2'd2) ? ch_ff + 2'd1 : ch_ff;

   // gradient of the current channel
   logic [7:0]        p [9];
   logic signed [11:0] gx, gy;
   logic [17:0]       ssum;
   always_comb begin
      for (int k = 0; k < 9; k++)
         p[k] = mask_ff[k] ? cw_ff[k][8*(2-32'(ch_sel)) +: 8] : 8'd0;
      gx = 12'(p[2]) + 12'(p[5]) * 12'sd2 + 12'(p[8])
         - 12'(p[0]) - 12'(p[3]) * 12'sd2 - 12'(p[6]);
      gy = 12'(p[6]) + 12'(p[7]) * 12'sd2 + 12'(p[8])
         - 12'(p[0]) - 12'(p[1]) * 12'sd2 - 12'(p[2]);
      ssum = 18'(24'(gx * gx) + 24'(gy * gy) > 24'd65535 ? 18'd65535 :
                 24'(gx * gx) + 24'(gy * gy));
   end

   sem_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .sum_in (ssum),
      .done   (sq_done),
      .root   (sq_root)
   );

   assign sq_start = emit_ff || (sq_done && chan_busy_ff && ch_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         pass2_ff <= 1'b0;
         emit_ff <= 1'b0;
         chan_busy_ff <= 1'b0;
         ch_ff <= '0;
      end else begin
         emit_ff <= cmd.step && emit_now;
         if (cmd.start) begin
            real_ff <= !in_action;
            pix_ff <= in_pix;
            pass2_ff <= 1'b0;
         end
         if (cmd.step) begin
            for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
            in_col_ff <= in_col_in; in_row_ff <= in_row_in;
            out_col_ff <= out_col_in; out_row_ff <= out_row_in;
            pass2_ff <= pass2_in;
            final_ff <= fin;
            if (emit_now) begin
               for (int i = 0; i < 9; i++) cw_ff[i] <= comp_win[i];
               mask_ff <= mask;
               chan_busy_ff <= 1'b1;
               ch_ff <= '0;
            end
         end
         if (sq_done) begin
            res_ff[8*(2-32'(ch_ff)) +: 8] <= sq_root;
            if (ch_ff == 2'd2) chan_busy_ff <= 1'b0;
            else ch_ff <= ch_ff + 2'd1;
         end
      end
   end

   // status
   always_comb begin
      sts.act_ok = real_ff ? !draining : draining;
      sts.again = pass2_in;
      sts.emitted = emit_now;
      sts.sqrt_done = sq_done && ch_ff == 2'd2;
   end

   assign res_edge = res_ff;
   assign res_last = final_ff;

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      ch_ff != 2'd3) else $error("channel index out of range");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> chan_busy_ff) else $error("sqrt start while idle");
   a_emit_step: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> $past(cmd.step)) else $error("emit without step");
endmodule
`default_nettype wire

// File: src/sobel_edge_magnitude_rgb.sv
`default_nettype none
// Channel  | Ports               | Direction
// req      | req_valid/req_ready | in : action, pixel_red/green/blue
// rsp      | rsp_valid/rsp_ready | out: edge_red/green/blue, frame_last
// csr      | APB psel/penable    | in : image_width (0x0), image_height (0x4)
// A transaction with no result is either ignored or makes one advance pass
// (line store read, then pass); a flush may need two passes. One with a result
// runs the shared square-root unit for each color in turn before it is sent.
// The result sits in an output register; the next transaction is accepted
// once it is loaded. Reset is synchronous and clears counters and window.
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MaxWidthDefault
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_pixel_red,
   input  wire logic [7:0]  req_pixel_green,
   input  wire logic [7:0]  req_pixel_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_edge_red,
   output logic [7:0]       rsp_edge_green,
   output logic [7:0]       rsp_edge_blue,
   output logic             rsp_frame_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic        in_fire;
   logic [23:0] res_edge;
   logic        res_last;
   logic        rsp_valid_ff;
   logic [24:0] rsp_data_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd1024;
         height_ff <= 16'd768;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (32'(csr_paddr[2]) == CfgWidthIdx && csr_paddr[1:0] == 2'd0)
            width_ff <= csr_pwdata[10:0];
         else if (32'(csr_paddr[2]) == CfgHeightIdx && csr_paddr[1:0] == 2'd0)
            height_ff <= csr_pwdata[15:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == 3'd0) csr_prdata = 32'(width_ff);
      else if (csr_paddr == 3'd4) csr_prdata = 32'(height_ff);
   end

   assign in_fire = req_valid && req_ready;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .out_busy  (rsp_valid_ff && !rsp_ready),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_action    (req_action),
      .in_pix       ({req_pixel_red, req_pixel_green, req_pixel_blue}),
      .image_width  (width_ff),
      .image_height (height_ff),
      .res_edge     (res_edge),
      .res_last     (res_last)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.send) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.send) rsp_data_ff <= {res_last, res_edge};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge_red = rsp_data_ff[23:16];
   assign rsp_edge_green = rsp_data_ff[15:8];
   assign rsp_edge_blue = rsp_data_ff[7:0];
   assign rsp_frame_last = rsp_data_ff[24];

   a_send_free: assert property (@(posedge clock) disable iff (reset)
      cmd.send |-> !rsp_valid_ff || rsp_ready) else $error("result overwritten");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> !cmd.send) else $error("accept during send");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("rsp dropped");
endmodule
`default_nettype wire

// File: verif/tb_sobel_edge_magnitude_rgb.sv
`default_nettype none

// Tracks pixel and flush transactions, predicts edge results, checks them in order
class edge_scoreboard;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } edge_item_type;

   int unsigned cfg_width;
   int unsigned cfg_height;
   logic [23:0] upper_row[1024];
   logic [23:0] lower_row[1024];
   logic [23:0] win[9];
   int unsigned in_col, in_row, out_col, out_row;
   edge_item_type pending[$];
   int          errors;

   function new();
      cfg_width  = 1024;
      cfg_height = 768;
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      errors  = 0;
   endfunction

   function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endfunction

   function void write_cfg(int unsigned idx, logic [31:0] value);
      if (idx == sem_pkg::CfgWidthIdx) cfg_width = value & 32'h7FF;
      else if (idx == sem_pkg::CfgHeightIdx) cfg_height = value & 32'hFFFF;
   endfunction

   function int unsigned live_width();
      int unsigned w;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > 1024) w = 1024;
      return w;
   endfunction

   function int unsigned live_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function bit draining();
      return in_row >= live_height();
   endfunction

   function bit frame_idle();
      return in_row == 0 && in_col == 0;
   endfunction

   function void shift_col(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
      logic [23:0] col[3];
      col[0] = top;
      col[1] = mid;
      col[2] = bot;
      for (int i = 0; i < 3; i++) begin
         win[i*3+0] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
         win[i*3+2] = col[i];
      end
   endfunction

   // integer square root, round half up, clamped to 8 bits
   function logic [7:0] root_round(int unsigned s);
      int unsigned q;
      q = 0;
      if (s >= 65281) return 8'd255;
      while ((q + 1) * (q + 1) <= s) q++;
      if (s > q * q + q) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function edge_item_type gradient(int unsigned w, int unsigned h);
      int kx[9];
      int ky[9];
      int gx[3];
      int gy[3];
      int p;
      logic [7:0] mag[3];
      edge_item_type res;
      kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
      ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
      gx = '{0, 0, 0};
      gy = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         if (i == 0 && out_row == 0) continue;
         if (i == 2 && out_row + 1 >= h) continue;
         for (int j = 0; j < 3; j++) begin
            if (j == 0 && out_col == 0) continue;
            if (j == 2 && out_col + 1 >= w) continue;
            for (int ch = 0; ch < 3; ch++) begin
               p = (win[i*3+j] >> (16 - 8 * ch)) & 8'hFF;
               gx[ch] += p * kx[i*3+j];
               gy[ch] += p * ky[i*3+j];
            end
         end
      end
      for (int ch = 0; ch < 3; ch++) mag[ch] = root_round(gx[ch] * gx[ch] + gy[ch] * gy[ch]);
      res.red   = mag[0];
      res.green = mag[1];
      res.blue  = mag[2];
      res.last  = 1'b0;
      return res;
   endfunction

   // one raster step; returns 1 when a result is produced
   function bit advance(bit live, logic [23:0] pix, output edge_item_type res);
      int unsigned w, h, c, r;
      bit may_emit, is_end, got;
      w = live_width();
      h = live_height();
      c = in_col;
      r = in_row;
      may_emit = (r >= 2) || (r == 1 && c >= 1);
      is_end = 0;
      got = 0;
      res = '{default: '0};
      if (c == 0) begin
         shift_col('0, '0, '0);
         if (may_emit) begin
            res = gradient(w, h);
            got = 1;
         end
         if (!live && r >= h + 1) is_end = 1;
      end
      if (!is_end) begin
         shift_col(upper_row[c % 1024], lower_row[c % 1024], live ? pix : 24'd0);
         if (c != 0 && may_emit) begin
            res = gradient(w, h);
            got = 1;
         end
      end
      if (live) begin
         upper_row[c % 1024] = lower_row[c % 1024];
         lower_row[c % 1024] = pix;
      end
      if (is_end) begin
         res.last = 1'b1;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         return got;
      end
      if (c + 1 >= w) begin
         in_col = 0;
         in_row = r + 1;
      end else begin
         in_col = c + 1;
      end
      if (got) begin
         if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
      end
      return got;
   endfunction

   function void note_input(bit action, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      edge_item_type res;
      if (action == 1'b0) begin
         if (draining()) return;
         if (advance(1, {r, g, b}, res)) pending.push_back(res);
      end else begin
         if (!draining()) return;
         for (int t = 0; t < 2; t++) begin
            if (advance(0, '0, res)) begin
               pending.push_back(res);
               return;
            end
         end
      end
   endfunction

   function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
      edge_item_type exp_res;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result %0d/%0d/%0d last=%0d", r, g, b, last));
         return;
      end
      exp_res = pending.pop_front();
      if (r !== exp_res.red || g !== exp_res.green || b !== exp_res.blue ||
          last !== exp_res.last)
         report($sformatf("got %0d/%0d/%0d last=%0d, want %0d/%0d/%0d last=%0d",
                          r, g, b, last, exp_res.red, exp_res.green, exp_res.blue,
                          exp_res.last));
   endfunction

endclass

module tb_sobel_edge_magnitude_rgb;
   import sem_pkg::*;

   localparam int StallLimit = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_pixel_red = '0;
   logic [7:0]  req_pixel_green = '0;
   logic [7:0]  req_pixel_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_edge_red;
   logic [7:0]  rsp_edge_green;
   logic [7:0]  rsp_edge_blue;
   logic        rsp_frame_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   edge_scoreboard sb = new();
   int unsigned    items_sent = 0;
   int unsigned    burst_left = 4;
   int unsigned    idle_cycles = 0;
   int unsigned    ready_mode = 0;
   int unsigned    ready_count = 0;

   sobel_edge_magnitude_rgb u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_pixel_red(req_pixel_red), .req_pixel_green(req_pixel_green),
      .req_pixel_blue(req_pixel_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_edge_red(rsp_edge_red), .rsp_edge_green(rsp_edge_green),
      .rsp_edge_blue(rsp_edge_blue), .rsp_frame_last(rsp_frame_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver stall pattern with a randomly chosen mode
   always @(posedge clock) begin
      ready_count <= ready_count + 1;
      if (ready_count % 50 == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ready_count[3];
      endcase
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_edge_red, rsp_edge_green, rsp_edge_blue, rsp_frame_last);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("tb_sobel_edge_magnitude_rgb: errors");
         $finish;
      end
   end

   // one transaction on the request channel, with burst/gap pacing
   task automatic push(bit action, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_valid       <= 1'b1;
      req_action      <= action;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_input(action, r, g, b);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // quiesce: all results in, then enough cycles for a trailing no-result flush
   task automatic settle();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0 && guard < 20 * StallLimit) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(int unsigned idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == CfgWidthIdx) ? 32'h7FF : 32'hFFFF;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_cfg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== (value & mask))
         sb.report($sformatf("csr %0d read %0h, want %0h", idx, csr_prdata, value & mask));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // one frame: pixels until draining, then flushes to the frame_last result
   task automatic run_frame(logic [31:0] w, logic [31:0] h, bit noise);
      settle();
      csr_write(CfgWidthIdx, w);
      csr_write(CfgHeightIdx, h);
      while (!sb.draining()) begin
         if (noise && $urandom_range(0, 9) == 0)
            push(1'b1, rand_chan(), rand_chan(), rand_chan());
         push(1'b0, rand_chan(), rand_chan(), rand_chan());
      end
      while (!sb.frame_idle()) begin
         if (noise && $urandom_range(0, 9) == 0)
            push(1'b0, rand_chan(), rand_chan(), rand_chan());
         push(1'b1, rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   initial begin
      int unsigned big_frames;
      big_frames = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray flush, tiny and degenerate frames, register extremes
      push(1'b1, 8'd255, 8'd255, 8'd255);
      run_frame(3, 3, 1);
      run_frame(1, 1, 1);
      run_frame(0, 0, 1);
      run_frame(4, 1, 1);
      run_frame(1, 4, 1);
      settle();
      csr_write(CfgHeightIdx, 32'hFFFF_FFFF);
      csr_write(CfgWidthIdx, 32'hFFFF_FFFF);
      run_frame(700, 1, 0);

      // random frames, mostly small
      while (items_sent < 1650) begin
         if (big_frames < 1 && $urandom_range(0, 40) == 0) begin
            big_frames++;
            run_frame($urandom_range(50, 100), $urandom_range(1, 2), 1);
         end else begin
            run_frame($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(0, 1));
         end
      end

      settle();
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.errors == 0) begin
         $display("tb_sobel_edge_magnitude_rgb: clean");
      end else begin
         $display("tb_sobel_edge_magnitude_rgb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
